[hdl/envc_pkg.sv]
// shared types, register indexes and helpers for the environmental compensation pipeline
package envc_pkg;

  localparam int unsigned NumStages = 47;
  localparam int unsigned DivFirst  = 12;
  localparam int unsigned DivBits   = 32;
  localparam int unsigned PostFirst = DivFirst + DivBits;

  localparam logic [2:0] CfgTemperature  = 3'd0;
  localparam logic [2:0] CfgPressureLow  = 3'd1;
  localparam logic [2:0] CfgPressureHigh = 3'd2;
  localparam logic [2:0] CfgP9Humidity   = 3'd3;
  localparam logic [2:0] CfgHumidityRest = 3'd4;

  localparam logic [31:0] HumClamp = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic [16:0] humidity_q10;
    logic        pressure_divisor_zero;
  } out_t;

  typedef struct packed {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tm1;
    logic [31:0] tbb;
    logic [31:0] tv1;
    logic [31:0] t_fine;
    logic [31:0] tm5;
    logic [31:0] temp;
    logic [31:0] v1;
    logic [31:0] hv;
    logic [31:0] sq;
    logic [31:0] mp5;
    logic [31:0] mp2;
    logic [31:0] hx1;
    logic [31:0] y2m;
    logic [31:0] y3m;
    logic [31:0] v2;
    logic [31:0] d1;
    logic [31:0] hx;
    logic [31:0] y2;
    logic [31:0] y3;
    logic [31:0] y4;
    logic [31:0] x2;
    logic [31:0] divm;
    logic [31:0] pres0;
    logic [31:0] ym;
    logic [31:0] y;
    logic [31:0] hp;
    logic [31:0] hs;
    logic [16:0] hum;
    logic        dz;
    logic        big;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] rem;
    logic [31:0] pres;
    logic [31:0] ww;
    logic [31:0] m8;
    logic [31:0] s9m;
    logic [31:0] s8;
  } work_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

[hdl/environmental_sensor_compensation_unit.sv]
// top level: calibration registers and the pipelined compensation datapath
// usage
//   input channel in_valid_i / in_i / in_stall_o carries one raw sample set per request
//   output channel out_valid_o / out_o / out_stall_i carries temperature, pressure,
//   humidity and the zero-divisor flag for that request, in order
//   calibration is to be written by the user through cfg_we_i / cfg_index_i / cfg_data_i
//   while idle; the block itself does not enforce this
// depth and throughput
//   47 register stages; one request per cycle sustained while out_stall_i is low, since
//   every stage is a full register stage; the depth is mostly the 32-stage restoring
//   divider, one quotient bit per stage
// stalls
//   each stage moves on when it is empty or the next stage moves, so bubbles close
//   up and new requests are still taken while a finished result waits at the output
//   nothing is dropped or repeated under stall
// reset
//   asynchronous, active low; clears all stage valid bits and all calibration words
module environmental_sensor_compensation_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  envc_pkg::in_t  in_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output envc_pkg::out_t out_o,
  input  logic           out_stall_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i
);
  import envc_pkg::*;

  // calibration words
  logic [47:0] cal_t_q;
  logic [63:0] cal_pl_q;
  logic [63:0] cal_ph_q;
  logic [47:0] cal_ph9_q;
  logic [31:0] cal_hr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q   <= '0;
      cal_pl_q  <= '0;
      cal_ph_q  <= '0;
      cal_ph9_q <= '0;
      cal_hr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTemperature:  cal_t_q   <= cfg_data_i[47:0];
        CfgPressureLow:  cal_pl_q  <= cfg_data_i;
        CfgPressureHigh: cal_ph_q  <= cfg_data_i;
        CfgP9Humidity:   cal_ph9_q <= cfg_data_i[47:0];
        CfgHumidityRest: cal_hr_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // coefficient fields, extended to the 32-bit datapath
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = 32'(cal_t_q[15:0]);
  assign t2 = 32'($signed(cal_t_q[31:16]));
  assign t3 = 32'($signed(cal_t_q[47:32]));
  assign p1 = 32'(cal_pl_q[15:0]);
  assign p2 = 32'($signed(cal_pl_q[31:16]));
  assign p3 = 32'($signed(cal_pl_q[47:32]));
  assign p4 = 32'($signed(cal_pl_q[63:48]));
  assign p5 = 32'($signed(cal_ph_q[15:0]));
  assign p6 = 32'($signed(cal_ph_q[31:16]));
  assign p7 = 32'($signed(cal_ph_q[47:32]));
  assign p8 = 32'($signed(cal_ph_q[63:48]));
  assign p9 = 32'($signed(cal_ph9_q[15:0]));
  assign h1 = 32'(cal_ph9_q[23:16]);
  assign h2 = 32'($signed(cal_ph9_q[39:24]));
  assign h3 = 32'(cal_ph9_q[47:40]);
  assign h4 = 32'($signed(cal_hr_q[11:0]));
  assign h5 = 32'($signed(cal_hr_q[23:12]));
  assign h6 = 32'($signed(cal_hr_q[31:24]));

  // pipeline storage
  work_t st_q [NumStages];
  work_t st_d [NumStages];
  logic  vld_q [NumStages];
  logic  adv [NumStages];

  // stage advance: move when empty or when the next stage moves
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  logic [32:0] shl_rem;

  always_comb begin
    shl_rem = '0;
    // stage 0: capture
    st_d[0]       = st_q[0];
    st_d[0].adc_t = in_i.raw_temperature;
    st_d[0].adc_p = in_i.raw_pressure;
    st_d[0].adc_h = in_i.raw_humidity;

    // stage 1: temperature offsets
    st_d[1]    = st_q[0];
    st_d[1].ta = 32'(st_q[0].adc_t >> 3) - (t1 << 1);
    st_d[1].tb = 32'(st_q[0].adc_t >> 4) - t1;

    // stage 2
    st_d[2]     = st_q[1];
    st_d[2].tm1 = st_q[1].ta * t2;
    st_d[2].tbb = st_q[1].tb * st_q[1].tb;

    // stage 3
    st_d[3]     = st_q[2];
    st_d[3].tv1 = asr(st_q[2].tm1, 11);
    st_d[3].tbb = asr(st_q[2].tbb, 12) * t3;

    // stage 4: fine temperature
    st_d[4]        = st_q[3];
    st_d[4].t_fine = st_q[3].tv1 + asr(st_q[3].tbb, 14);

    // stage 5
    st_d[5]     = st_q[4];
    st_d[5].tm5 = st_q[4].t_fine * 32'd5;
    st_d[5].v1  = asr(st_q[4].t_fine, 1) - 32'd64000;
    st_d[5].hv  = st_q[4].t_fine - 32'd76800;

    // stage 6: final temperature, first products of pressure and humidity
    st_d[6]      = st_q[5];
    st_d[6].temp = asr(st_q[5].tm5 + 32'd128, 8);
    st_d[6].sq   = asr(st_q[5].v1, 2) * asr(st_q[5].v1, 2);
    st_d[6].mp5  = st_q[5].v1 * p5;
    st_d[6].mp2  = p2 * st_q[5].v1;
    st_d[6].hx1  = h5 * st_q[5].hv;
    st_d[6].y2m  = st_q[5].hv * h6;
    st_d[6].y3m  = st_q[5].hv * h3;

    // stage 7
    st_d[7]    = st_q[6];
    st_d[7].v2 = asr(st_q[6].sq, 11) * p6;
    st_d[7].d1 = p3 * asr(st_q[6].sq, 13);
    st_d[7].hx = (32'(st_q[6].adc_h) << 14) - (h4 << 20) - st_q[6].hx1;
    st_d[7].y2 = asr(st_q[6].y2m, 10);
    st_d[7].y3 = asr(st_q[6].y3m, 11);

    // stage 8
    st_d[8]      = st_q[7];
    st_d[8].v2   = st_q[7].v2 + (st_q[7].mp5 << 1);
    st_d[8].divm = asr(asr(st_q[7].d1, 3) + asr(st_q[7].mp2, 1), 18);
    st_d[8].x2   = asr(st_q[7].hx + 32'd16384, 15);
    st_d[8].y4   = st_q[7].y2 * (st_q[7].y3 + 32'd32768);

    // stage 9
    st_d[9]      = st_q[8];
    st_d[9].v2   = asr(st_q[8].v2, 2) + (p4 << 16);
    st_d[9].divm = (32'd32768 + st_q[8].divm) * p1;
    st_d[9].y4   = asr(st_q[8].y4, 10) + 32'd2097152;

    // stage 10
    st_d[10]       = st_q[9];
    st_d[10].den   = asr(st_q[9].divm, 15);
    st_d[10].pres0 = (32'd1048576 - 32'(st_q[9].adc_p) - asr(st_q[9].v2, 12)) * 32'd3125;
    st_d[10].ym    = st_q[9].y4 * h2;

    // stage 11: dividend set-up
    st_d[11]     = st_q[10];
    st_d[11].dz  = (st_q[10].den == '0);
    st_d[11].big = st_q[10].pres0[31];
    st_d[11].num = st_q[10].pres0[31] ? st_q[10].pres0 : (st_q[10].pres0 << 1);
    st_d[11].rem = '0;
    st_d[11].y   = asr(st_q[10].ym + 32'd8192, 14);

    // restoring divider, one quotient bit per stage; humidity finishes alongside
    for (int g = 0; g < DivBits; g++) begin
      st_d[DivFirst+g] = st_q[DivFirst+g-1];
    end
    st_d[DivFirst].hp   = st_q[DivFirst-1].x2 * st_q[DivFirst-1].y;
    st_d[DivFirst+1].hs = asr(st_q[DivFirst].hp, 15) * asr(st_q[DivFirst].hp, 15);
    st_d[DivFirst+2].hs = asr(st_q[DivFirst+1].hs, 7) * h1;
    st_d[DivFirst+3].hp = st_q[DivFirst+2].hp - asr(st_q[DivFirst+2].hs, 4);
    if (st_q[DivFirst+3].hp[31]) begin
      st_d[DivFirst+4].hum = '0;
    end else if (st_q[DivFirst+3].hp > HumClamp) begin
      st_d[DivFirst+4].hum = 17'(HumClamp >> 12);
    end else begin
      st_d[DivFirst+4].hum = st_q[DivFirst+3].hp[28:12];
    end
    for (int g = 0; g < DivBits; g++) begin
      shl_rem = {st_q[DivFirst+g-1].rem, st_q[DivFirst+g-1].num[31]};
      st_d[DivFirst+g].num = st_q[DivFirst+g-1].num << 1;
      if (shl_rem >= {1'b0, st_q[DivFirst+g-1].den}) begin
        st_d[DivFirst+g].rem    = 32'(shl_rem - {1'b0, st_q[DivFirst+g-1].den});
        st_d[DivFirst+g].num[0] = 1'b1;
      end else begin
        st_d[DivFirst+g].rem = shl_rem[31:0];
      end
    end

    // post stage 1: undo the pre-scaling, start the correction products
    st_d[PostFirst]      = st_q[PostFirst-1];
    st_d[PostFirst].pres = st_q[PostFirst-1].big ? (st_q[PostFirst-1].num << 1)
                                                 : st_q[PostFirst-1].num;
    st_d[PostFirst].ww   = (st_d[PostFirst].pres >> 3) * (st_d[PostFirst].pres >> 3);
    st_d[PostFirst].m8   = (st_d[PostFirst].pres >> 2) * p8;

    // post stage 2
    st_d[PostFirst+1]     = st_q[PostFirst];
    st_d[PostFirst+1].s9m = p9 * (st_q[PostFirst].ww >> 13);
    st_d[PostFirst+1].s8  = asr(st_q[PostFirst].m8, 13);

    // post stage 3: final pressure
    st_d[PostFirst+2] = st_q[PostFirst+1];
    if (st_q[PostFirst+1].dz) begin
      st_d[PostFirst+2].pres = '0;
    end else begin
      st_d[PostFirst+2].pres = st_q[PostFirst+1].pres
        + asr(asr(st_q[PostFirst+1].s9m, 12) + st_q[PostFirst+1].s8 + p7, 4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_stall_o                  = !adv[0];
  assign out_valid_o                 = vld_q[NumStages-1];
  assign out_o.temperature_centi     = st_q[NumStages-1].temp;
  assign out_o.pressure_pa           = st_q[NumStages-1].pres;
  assign out_o.humidity_q10          = st_q[NumStages-1].hum;
  assign out_o.pressure_divisor_zero = st_q[NumStages-1].dz;

  // a zero divisor always forces zero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.pressure_divisor_zero |-> out_o.pressure_pa == '0)
    else $error("pressure not forced to zero on zero divisor");

  // humidity never exceeds the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.humidity_q10 <= 17'd102400)
    else $error("humidity above clamp");

  // an accepted request lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted request lost at entry");

  // a held result stays valid while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && out_stall_i |=> vld_q[NumStages-1])
    else $error("stalled result dropped");

endmodule

[tb/environmental_sensor_compensation_unit_tb.sv]
// testbench for the environmental sensor compensation unit: random and directed requests
`timescale 1ns / 100ps

module environmental_sensor_compensation_unit_tb;
  import envc_pkg::*;

  localparam int unsigned PipeDepth  = 47;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned QuietTail  = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  in_t         in_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_t        out_o;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  environmental_sensor_compensation_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_i, .in_stall_o, .out_valid_o, .out_o,
    .out_stall_i, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // calibration words as the predictor sees them
  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_ph;
  logic [47:0] cal_p9h;
  logic [31:0] cal_hr;

  in_t  pending_requests[$];
  out_t expected_results[$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   zero_div_seen = 0;
  int   clamp_seen = 0;
  int   cycle_count = 0;
  bit   idle_off = 1'b0;
  bit   hold_receiver = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  // stall seen at the rising edge, so the driver knows whether the request went in
  logic in_stall_o_q = 1'b0;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // integer compensation of one raw sample set
  function automatic out_t compensate(input in_t s);
    logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, v1, v2, tf, q, sq, dv, pr, w, s9, s8;
    logic [31:0] v, x, y2, y3, y4, y, sh;
    out_t r;
    at = {12'd0, s.raw_temperature};
    ap = {12'd0, s.raw_pressure};
    ah = {16'd0, s.raw_humidity};
    t1 = {16'd0, cal_t[15:0]};
    t2 = sx16(cal_t[31:16]);
    t3 = sx16(cal_t[47:32]);
    p1 = {16'd0, cal_pl[15:0]};
    p2 = sx16(cal_pl[31:16]);
    p3 = sx16(cal_pl[47:32]);
    p4 = sx16(cal_pl[63:48]);
    p5 = sx16(cal_ph[15:0]);
    p6 = sx16(cal_ph[31:16]);
    p7 = sx16(cal_ph[47:32]);
    p8 = sx16(cal_ph[63:48]);
    p9 = sx16(cal_p9h[15:0]);
    h1 = {24'd0, cal_p9h[23:16]};
    h2 = sx16(cal_p9h[39:24]);
    h3 = {24'd0, cal_p9h[47:40]};
    h4 = {{20{cal_hr[11]}}, cal_hr[11:0]};
    h5 = {{20{cal_hr[23]}}, cal_hr[23:12]};
    h6 = {{24{cal_hr[31]}}, cal_hr[31:24]};
    r = '0;
    // fine temperature
    a = sra(at, 3) - (t1 << 1);
    v1 = sra(a * t2, 11);
    b = sra(at, 4) - t1;
    v2 = sra(sra(b * b, 12) * t3, 14);
    tf = v1 + v2;
    r.temperature_centi = sra(tf * 32'd5 + 32'd128, 8);
    // pressure
    v1 = sra(tf, 1) - 32'd64000;
    q = sra(v1, 2);
    sq = q * q;
    v2 = sra(sq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    dv = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
    dv = sra((32'd32768 + dv) * p1, 15);
    if (dv == 32'd0) begin
      r.pressure_pa = '0;
      r.pressure_divisor_zero = 1'b1;
    end else begin
      pr = (32'd1048576 - ap - sra(v2, 12)) * 32'd3125;
      if (pr < 32'h8000_0000) pr = (pr << 1) / dv;
      else pr = (pr / dv) << 1;
      w = pr >> 3;
      s9 = sra(p9 * ((w * w) >> 13), 12);
      s8 = sra((pr >> 2) * p8, 13);
      r.pressure_pa = pr + sra(s9 + s8 + p7, 4);
    end
    // humidity
    v = tf - 32'd76800;
    x = (ah << 14) - (h4 << 20) - h5 * v;
    x = sra(x + 32'd16384, 15);
    y2 = sra(v * h6, 10);
    y3 = sra(v * h3, 11);
    y4 = sra(y2 * (y3 + 32'd32768), 10) + 32'd2097152;
    y = sra(y4 * h2 + 32'd8192, 14);
    v = x * y;
    sh = sra(v, 15);
    v = v - sra(sra(sh * sh, 7) * h1, 4);
    if (v[31]) v = '0;
    else if (v > HumClamp) v = HumClamp;
    r.humidity_q10 = 17'(v >> 12);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
             results_seen);
    mismatch_count++;
  endtask

  task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgTemperature:  cal_t = val[47:0];
      CfgPressureLow:  cal_pl = val;
      CfgPressureHigh: cal_ph = val;
      CfgP9Humidity:   cal_p9h = val[47:0];
      CfgHumidityRest: cal_hr = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // calibration near typical part values with some random spread
  task automatic load_typical_cal();
    write_cal(CfgTemperature, {16'(-32'sd1000 + $urandom_range(0, 2000)),
                               16'(26000 + $urandom_range(0, 2000)),
                               16'(27000 + $urandom_range(0, 2000))});
    write_cal(CfgPressureLow, {16'(2000 + $urandom_range(0, 8000)),
                               16'(4000 + $urandom_range(0, 2000)),
                               16'(-32'sd11000 + $urandom_range(0, 1000)),
                               16'(36000 + $urandom_range(0, 2000))});
    write_cal(CfgPressureHigh, {16'(-32'sd12000 + $urandom_range(0, 2000)),
                                16'(15000 + $urandom_range(0, 1000)),
                                16'(-32'sd20 + $urandom_range(0, 40)),
                                16'(-32'sd100 + $urandom_range(0, 200))});
    write_cal(CfgP9Humidity, {8'($urandom_range(0, 255)),
                              16'(300 + $urandom_range(0, 200)),
                              8'($urandom_range(0, 255)),
                              16'(4000 + $urandom_range(0, 2000))});
    write_cal(CfgHumidityRest, {8'($urandom_range(0, 60)),
                                12'($urandom_range(0, 100)),
                                12'(250 + $urandom_range(0, 200))});
  endtask

  task automatic queue_request(input logic [19:0] t, input logic [19:0] p,
                               input logic [15:0] h);
    in_t s;
    s.raw_temperature = t;
    s.raw_pressure = p;
    s.raw_humidity = h;
    pending_requests.push_back(s);
  endtask

  // wait for the pipeline to drain before touching calibration
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
  endtask

  // driver: offers the head of the pending queue, idling in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o_q) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_i <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
          if (!idle_off && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_results.push_back(compensate(in_i));
  end

  // receiver stall: random bursts, or a long hold when asked
  always @(negedge clk_i) begin
    if (hold_receiver) begin
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!idle_off && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 18);
    end
  end

  // monitor: compares each result with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_o.pressure_pa, '0);
      end else begin
        want = expected_results.pop_front();
        if (want.pressure_divisor_zero) zero_div_seen++;
        if (want.humidity_q10 == 17'd102400) clamp_seen++;
        if (out_o.temperature_centi !== want.temperature_centi)
          report_mismatch("temperature_centi", out_o.temperature_centi,
                          want.temperature_centi);
        if (out_o.pressure_pa !== want.pressure_pa)
          report_mismatch("pressure_pa", out_o.pressure_pa, want.pressure_pa);
        if (out_o.humidity_q10 !== want.humidity_q10)
          report_mismatch("humidity_q10", 32'(out_o.humidity_q10), 32'(want.humidity_q10));
        if (out_o.pressure_divisor_zero !== want.pressure_divisor_zero)
          report_mismatch("pressure_divisor_zero", 32'(out_o.pressure_divisor_zero),
                          32'(want.pressure_divisor_zero));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("environmental_sensor_compensation_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int hold_cycles;
    cal_t = '0;
    cal_pl = '0;
    cal_ph = '0;
    cal_p9h = '0;
    cal_hr = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all calibration zero after reset: divisor is zero
    queue_request('0, '0, '0);
    queue_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();

    // directed: field extremes with typical calibration
    load_typical_cal();
    queue_request('0, '0, '0);
    queue_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_request(20'h80000, 20'h80000, 16'h8000);
    queue_request(20'd519888, 20'd415148, 16'd27000);
    queue_request(20'd519888, 20'd0, 16'hFFFF);
    queue_request(20'd300000, 20'hFFFFF, 16'd0);
    queue_request(20'd700000, 20'd1, 16'd1);
    drain();

    // extreme calibration words: all ones, then sign bits only
    write_cal(CfgTemperature, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(CfgPressureLow, '1);
    write_cal(CfgPressureHigh, '1);
    write_cal(CfgP9Humidity, '1);
    write_cal(CfgHumidityRest, '1);
    queue_request('0, '0, '0);
    queue_request(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_request(20'h55555, 20'hAAAAA, 16'h5A5A);
    drain();
    write_cal(CfgTemperature, 64'h8000_8000_8000);
    write_cal(CfgPressureLow, 64'h8000_8000_8000_8000);
    write_cal(CfgPressureHigh, 64'h8000_8000_8000_8000);
    write_cal(CfgP9Humidity, 64'h80_8000_80_8000);
    write_cal(CfgHumidityRest, 64'h80_800_800);
    queue_request(20'hFFFFF, 20'h00000, 16'hFFFF);
    queue_request(20'h12345, 20'h54321, 16'h0F0F);
    // index beyond the list is ignored
    drain();
    write_cal(3'd7, '1);
    queue_request(20'h0AAAA, 20'hF0F0F, 16'hC3C3);
    drain();

    // random phases: typical calibration mostly, random words sometimes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        write_cal(CfgTemperature, rand64());
        write_cal(CfgPressureLow, rand64());
        write_cal(CfgPressureHigh, rand64());
        write_cal(CfgP9Humidity, rand64());
        write_cal(CfgHumidityRest, rand64());
      end else begin
        load_typical_cal();
      end
      if (ph == 5) idle_off = 1'b1;
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 3) == 0)
          queue_request(20'($urandom()), 20'($urandom()), 16'($urandom()));
        else
          queue_request(20'($urandom_range(380000, 640000)),
                        20'($urandom_range(200000, 600000)),
                        16'($urandom_range(15000, 50000)));
      end
      if (ph == 1) begin
        // long output hold so the pipeline fills and stalls its input
        hold_receiver = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 3 * PipeDepth) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        @(negedge clk_i);
        hold_receiver = 1'b0;
      end
      drain();
    end

    repeat (QuietTail) @(posedge clk_i);
    $display("covered %0d results under %0d calibration phases", results_seen, 10);
    $display("zero-divisor results %0d, clamped humidity results %0d",
             zero_div_seen, clamp_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("environmental_sensor_compensation_unit_tb OK");
    end else begin
      $display("environmental_sensor_compensation_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
